/* design/gmrot_pkg.sv */
// Shared types, constants and arithmetic helpers for the geomagnetic rotation block.
`timescale 1ns / 1ps
`default_nettype none
package gmrot_pkg;

  // Angle and fixed point constants
  localparam int unsigned TURN_UNITS    = 368640;       // 360 deg in 1/1024 deg
  localparam int unsigned HALF_TURN     = 184320;       // 180 deg
  localparam int          LAT_LIMIT     = 92160;        // 90 deg
  localparam int          LOW_LAT_LIMIT = 30720;        // 30 deg
  localparam int          GAIN_Q30      = 652032874;    // CORDIC gain, Q1.30
  localparam int          SNAP_Q30      = 1072668082;   // 0.999 in Q1.30
  localparam int unsigned BAM_SCALE     = 11650;        // integer part of 2^32 / 368640
  localparam int unsigned RECIP_90      = 47721858;     // floor(2^32 / 90)

  // Configuration register indexes
  localparam logic [1:0] CFG_POLE_LAT = 2'd0;
  localparam logic [1:0] CFG_POLE_LON = 2'd1;

  localparam logic signed [17:0] POLE_LAT_RESET = 18'sd81459;
  localparam logic signed [18:0] POLE_LON_RESET = -19'sd73288;

  // Datapath widths
  localparam int CW = 34;  // rotation CORDIC
  localparam int SW = 33;  // sines and cosines, Q1.30
  localparam int VW = 36;  // vectoring CORDIC

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [1:0]           quad;
  } rot_t;

  typedef struct packed {
    logic signed [SW-1:0] c;
    logic signed [SW-1:0] s;
  } cs_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [VW-1:0] s;
    logic signed [VW-1:0] xr;
    logic                 half;
    logic                 flag;
  } lon_side_t;

  typedef struct packed {
    logic [18:0] mlon;
    logic        snap_hi;
    logic        snap_lo;
    logic        flag;
  } lat_side_t;

  typedef struct packed {
    logic signed [17:0] mlat;
    logic [18:0]        mlon;
    logic               flag;
  } res_t;

  // Arctangent of 2^-i in binary angle units (full turn = 2^32)
  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // One rotation-mode CORDIC iteration
  function automatic rot_t rot_step(input rot_t a, input int unsigned i);
    rot_t                 r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;
    dx = a.y >>> i;
    dy = a.x >>> i;
    at = CW'(atan_bam(i[4:0]));
    r  = a;
    if (!a.z[CW-1]) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - at;
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + at;
    end
    return r;
  endfunction

  // One vectoring-mode CORDIC iteration
  function automatic vec_t vec_step(input vec_t a, input int unsigned i);
    vec_t                 r;
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;
    logic signed [VW-1:0] at;
    dx = a.y >>> i;
    dy = a.x >>> i;
    at = VW'(atan_bam(i[4:0]));
    if (a.y[VW-1]) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - at;
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + at;
    end
    return r;
  endfunction

  // Quadrant fold of the rotation result into cosine and sine
  function automatic cs_t quad_map(input rot_t a);
    cs_t                  r;
    logic signed [CW-1:0] nx;
    logic signed [CW-1:0] ny;
    nx = -a.x;
    ny = -a.y;
    case (a.quad)
      2'd0: begin r.c = a.x[SW-1:0]; r.s = a.y[SW-1:0]; end
      2'd1: begin r.c = ny[SW-1:0];  r.s = a.x[SW-1:0]; end
      2'd2: begin r.c = nx[SW-1:0];  r.s = ny[SW-1:0];  end
      default: begin r.c = a.y[SW-1:0]; r.s = nx[SW-1:0]; end
    endcase
    return r;
  endfunction

  // Q1.30 product back to Q1.30, half away from zero
  function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
    logic signed [65:0] a;
    if (!v[65]) a = (v + 66'sh20000000) >>> 30;
    else        a = -((-v + 66'sh20000000) >>> 30);
    return a[35:0];
  endfunction

  // Drop 32 fraction bits, half away from zero
  function automatic logic signed [23:0] rnd32(input logic signed [55:0] v);
    logic signed [55:0] a;
    if (!v[55]) a = (v + 56'sh80000000) >>> 32;
    else        a = -((-v + 56'sh80000000) >>> 32);
    return a[23:0];
  endfunction

endpackage
`default_nettype wire

/* design/geomagnetic_coordinate_rotation_top.sv */
// Geomagnetic coordinate rotation: pipelined CORDIC datapath, top level.
// One coordinate pair is taken every clock cycle while the input is not
// stalled. The pipeline is made of three chained CORDIC units (sine/cosine,
// longitude vectoring, latitude vectoring), one iteration per register stage,
// plus the angle conversion and multiplier stages. The input stall rises only
// when the output is held and the one-entry skid register behind it has
// filled. Pole registers are to be written only while the block is idle; the
// block itself does not enforce this. Index 0 is the pole latitude, index 1
// the pole longitude, other indexes are ignored. Inputs within 30 degrees of
// the equator are rotated the same way and marked by the flag.
`timescale 1ns / 1ps
`default_nettype none
module geomagnetic_coordinate_rotation_top
  import gmrot_pkg::*;
#(
  parameter int CORDIC_STAGES = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [18:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic signed [17:0] geo_latitude_i,
  input  wire logic signed [19:0] geo_longitude_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic signed [17:0] mag_latitude_o,
  output      logic [18:0]        mag_longitude_o,
  output      logic               low_latitude_flag_o
);

  localparam int N = CORDIC_STAGES;
  localparam logic signed [20:0] TURN21 = 21'(TURN_UNITS);

  // Pole registers
  logic signed [17:0] pole_lat_q;
  logic signed [18:0] pole_lon_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_lat_q <= POLE_LAT_RESET;
      pole_lon_q <= POLE_LON_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_POLE_LAT: pole_lat_q <= cfg_data_i[17:0];
        CFG_POLE_LON: pole_lon_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves while the skid register is empty
  logic skid_v_q;
  logic en;
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // ---------------- Angle conversion (lanes: lat, lon, pole lat, pole lon)
  logic signed [20:0] w_lat, w_lon, w_plat, w_plon, t_lon;
  logic signed [20:0] r_lat, r_lon, r_plat, r_plon;
  logic               flag_d;

  always_comb begin
    w_lat  = 21'(geo_latitude_i);
    w_lon  = 21'(geo_longitude_i);
    w_plat = 21'(pole_lat_q);
    w_plon = 21'(pole_lon_q);
    r_lat  = w_lat[20]  ? w_lat + TURN21  : w_lat;
    r_plat = w_plat[20] ? w_plat + TURN21 : w_plat;
    r_plon = w_plon[20] ? w_plon + TURN21 : w_plon;
    t_lon  = w_lon[20]  ? w_lon + TURN21  : w_lon;
    if (t_lon[20])            r_lon = t_lon + TURN21;
    else if (t_lon >= TURN21) r_lon = t_lon - TURN21;
    else                      r_lon = t_lon;
    flag_d = (geo_latitude_i <= 18'sd30720) && (geo_latitude_i >= -18'sd30720);
  end

  logic [3:0]  c_v_q;
  logic [3:0]  c_flag_q;
  logic [18:0] cu_q   [4];
  logic [24:0] cv_q   [4];
  logic [31:0] chi_q  [4];
  logic [18:0] cq0_q  [4];
  logic [24:0] cv2_q  [4];
  logic [31:0] chi2_q [4];
  logic [31:0] bam_q  [4];
  logic [50:0] cprod  [4];
  logic [24:0] crem   [4];
  logic [18:0] cqq    [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      cprod[l] = 51'(cv_q[l]) * 51'(RECIP_90);
      crem[l]  = cv2_q[l] - 25'(cq0_q[l]) * 25'd90;
      cqq[l]   = cq0_q[l] + ((crem[l] >= 25'd90) ? 19'd1 : 19'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // reduced angle, then bam = 11650*u + floor((76*u + 45) / 90)
      cu_q[0] <= r_lat[18:0];
      cu_q[1] <= r_lon[18:0];
      cu_q[2] <= r_plat[18:0];
      cu_q[3] <= r_plon[18:0];
      for (int l = 0; l < 4; l++) begin
        cv_q[l]   <= 25'(cu_q[l]) * 25'd76 + 25'd45;
        chi_q[l]  <= 32'(cu_q[l]) * 32'(BAM_SCALE);
        cq0_q[l]  <= cprod[l][50:32];
        cv2_q[l]  <= cv_q[l];
        chi2_q[l] <= chi_q[l];
        bam_q[l]  <= chi2_q[l] + 32'(cqq[l]);
      end
      c_flag_q <= {c_flag_q[2:0], flag_d};
    end
  end

  // ---------------- Sine/cosine CORDIC (lanes: lat, pole lat, delta lon)
  rot_t        rot_q  [N+1][3];
  logic [N:0]  rot_v_q;
  logic [N:0]  rot_f_q;
  logic [31:0] dl;

  assign dl = bam_q[1] - bam_q[3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rot_q[0][0] <= '{x: CW'(GAIN_Q30), y: '0, z: CW'(bam_q[0][29:0]), quad: bam_q[0][31:30]};
      rot_q[0][1] <= '{x: CW'(GAIN_Q30), y: '0, z: CW'(bam_q[2][29:0]), quad: bam_q[2][31:30]};
      rot_q[0][2] <= '{x: CW'(GAIN_Q30), y: '0, z: CW'(dl[29:0]), quad: dl[31:30]};
      for (int i = 0; i < N; i++) begin
        for (int l = 0; l < 3; l++) begin
          rot_q[i+1][l] <= rot_step(rot_q[i][l], i);
        end
      end
      rot_f_q <= {rot_f_q[N-1:0], c_flag_q[3]};
    end
  end

  // ---------------- Rotation products
  cs_t                  cs_lat, cs_pol, cs_dl;
  logic signed [SW-1:0] cl_q, sl_q, cp_q, sp_q, cd_q, sd_q;
  logic signed [65:0]   pcx_q, pcy_q;
  logic signed [SW-1:0] sl1_q, cp1_q, sp1_q;
  logic signed [SW-1:0] x2_q, y2_q, sl2_q, cp2_q, sp2_q;
  logic signed [65:0]   m0_q, m1_q, m2_q, m3_q;
  logic signed [SW-1:0] y3_q;
  logic signed [VW-1:0] s4_q, xr4_q, y4_q;
  logic signed [35:0]   x2_full, y2_full;
  logic [4:0]           p_v_q;
  logic [4:0]           p_f_q;

  assign cs_lat  = quad_map(rot_q[N][0]);
  assign cs_pol  = quad_map(rot_q[N][1]);
  assign cs_dl   = quad_map(rot_q[N][2]);
  assign x2_full = rnd30(pcx_q);
  assign y2_full = rnd30(pcy_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      cl_q  <= cs_lat.c;
      sl_q  <= cs_lat.s;
      cp_q  <= cs_pol.c;
      sp_q  <= cs_pol.s;
      cd_q  <= cs_dl.c;
      sd_q  <= cs_dl.s;
      pcx_q <= cl_q * cd_q;
      pcy_q <= cl_q * sd_q;
      sl1_q <= sl_q;
      cp1_q <= cp_q;
      sp1_q <= sp_q;
      x2_q  <= x2_full[SW-1:0];
      y2_q  <= y2_full[SW-1:0];
      sl2_q <= sl1_q;
      cp2_q <= cp1_q;
      sp2_q <= sp1_q;
      m0_q  <= x2_q * cp2_q;
      m1_q  <= sl2_q * sp2_q;
      m2_q  <= x2_q * sp2_q;
      m3_q  <= sl2_q * cp2_q;
      y3_q  <= y2_q;
      s4_q  <= rnd30(m0_q) + rnd30(m1_q);
      xr4_q <= rnd30(m2_q) - rnd30(m3_q);
      y4_q  <= VW'(y3_q);
      p_f_q <= {p_f_q[3:0], rot_f_q[N]};
    end
  end

  // ---------------- Longitude vectoring, (xr, y) folded into the right half plane
  vec_t       lon_q  [N+1];
  lon_side_t  lsd_q  [N+1];
  logic [N:0] lon_v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lon_q[0].x <= xr4_q[VW-1] ? -xr4_q : xr4_q;
      lon_q[0].y <= xr4_q[VW-1] ? -y4_q : y4_q;
      lon_q[0].z <= '0;
      lsd_q[0]   <= '{s: s4_q, xr: xr4_q, half: xr4_q[VW-1], flag: p_f_q[4]};
      for (int i = 0; i < N; i++) begin
        lon_q[i+1] <= vec_step(lon_q[i], i);
        lsd_q[i+1] <= lsd_q[i];
      end
    end
  end

  // ---------------- Magnitude, longitude output and snap tests
  logic signed [65:0]   gp1_q;
  logic [31:0]          lbam1_q;
  logic signed [VW-1:0] s1_q, xr1_q, s2_q, xr2_q, r2_q, s3_q, r3_q, s4b_q, r4_q;
  logic [50:0]          lm2_q;
  logic signed [47:0]   a3_q, b3_q;
  logic [18:0]          mraw3_q, mlon4_q;
  logic [51:0]          lm_sum;
  logic                 hi4_q, lo4_q;
  logic [3:0]           r_v_q;
  logic [3:0]           r_f_q;
  logic [18:0]          mlon_d;

  assign lm_sum = 52'(lm2_q) + 52'h0_8000_0000;

  always_comb begin
    if (a3_q > b3_q)                     mlon_d = '0;
    else if (a3_q < -b3_q)               mlon_d = 19'(HALF_TURN);
    else if (mraw3_q >= 19'(TURN_UNITS)) mlon_d = '0;
    else                                 mlon_d = mraw3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gp1_q   <= lon_q[N].x * 32'sd652032874;
      lbam1_q <= lon_q[N].z[31:0] + {lsd_q[N].half, 31'd0};
      s1_q    <= lsd_q[N].s;
      xr1_q   <= lsd_q[N].xr;
      r2_q    <= rnd30(gp1_q);
      lm2_q   <= 51'(lbam1_q) * 51'(TURN_UNITS);
      s2_q    <= s1_q;
      xr2_q   <= xr1_q;
      a3_q    <= 48'(xr2_q) * 48'sd1000;
      b3_q    <= 48'(r2_q) * 48'sd999;
      mraw3_q <= lm_sum[50:32];
      s3_q    <= s2_q;
      r3_q    <= r2_q;
      mlon4_q <= mlon_d;
      s4b_q   <= s3_q;
      r4_q    <= r3_q;
      hi4_q   <= s3_q > VW'(SNAP_Q30);
      lo4_q   <= s3_q < -VW'(SNAP_Q30);
      r_f_q   <= {r_f_q[2:0], lsd_q[N].flag};
    end
  end

  // ---------------- Latitude vectoring on (r, s)
  vec_t       lat_q  [N+1];
  lat_side_t  asd_q  [N+1];
  logic [N:0] lat_v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lat_q[0] <= '{x: r4_q, y: s4b_q, z: '0};
      asd_q[0] <= '{mlon: mlon4_q, snap_hi: hi4_q, snap_lo: lo4_q, flag: r_f_q[3]};
      for (int i = 0; i < N; i++) begin
        lat_q[i+1] <= vec_step(lat_q[i], i);
        asd_q[i+1] <= asd_q[i];
      end
    end
  end

  // ---------------- Latitude scaling, saturation and snap
  logic signed [55:0] lp_q;
  lat_side_t          lsd1_q;
  res_t               res_q;
  logic [1:0]         l_v_q;
  logic signed [23:0] mlat_r;
  logic signed [17:0] mlat_d;

  assign mlat_r = rnd32(lp_q);

  always_comb begin
    if (lsd1_q.snap_hi)                mlat_d = 18'(LAT_LIMIT);
    else if (lsd1_q.snap_lo)           mlat_d = -18'(LAT_LIMIT);
    else if (mlat_r > 24'(LAT_LIMIT))  mlat_d = 18'(LAT_LIMIT);
    else if (mlat_r < -24'(LAT_LIMIT)) mlat_d = -18'(LAT_LIMIT);
    else                               mlat_d = mlat_r[17:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lp_q   <= 56'(lat_q[N].z) * 56'sd368640;
      lsd1_q <= asd_q[N];
      res_q  <= '{mlat: mlat_d, mlon: lsd1_q.mlon, flag: lsd1_q.flag};
    end
  end

  // ---------------- Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q   <= '0;
      rot_v_q <= '0;
      p_v_q   <= '0;
      lon_v_q <= '0;
      r_v_q   <= '0;
      lat_v_q <= '0;
      l_v_q   <= '0;
    end else if (en) begin
      c_v_q   <= {c_v_q[2:0], in_valid_i};
      rot_v_q <= {rot_v_q[N-1:0], c_v_q[3]};
      p_v_q   <= {p_v_q[3:0], rot_v_q[N]};
      lon_v_q <= {lon_v_q[N-1:0], p_v_q[4]};
      r_v_q   <= {r_v_q[2:0], lon_v_q[N]};
      lat_v_q <= {lat_v_q[N-1:0], r_v_q[3]};
      l_v_q   <= {l_v_q[0], lat_v_q[N]};
    end
  end

  // ---------------- Output register with skid entry
  logic out_v_q;
  res_t out_q, skid_q;
  logic push;
  logic take;

  assign push = l_v_q[1] && en;
  assign take = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || take) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= push;
      end
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || take) begin
      if (skid_v_q)  out_q <= skid_q;
      else if (push) out_q <= res_q;
    end else if (push) begin
      skid_q <= res_q;
    end
  end

  assign out_valid_o         = out_v_q;
  assign mag_latitude_o      = out_q.mlat;
  assign mag_longitude_o     = out_q.mlon;
  assign low_latitude_flag_o = out_q.flag;

endmodule
`default_nettype wire

/* design/gmrot_checker.sv */
// Port-level checker for the geomagnetic rotation block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module gmrot_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [17:0] mag_latitude_o,
  input wire logic [18:0]        mag_longitude_o,
  input wire logic               low_latitude_flag_o
);

  // Input stall only while a result is held at the output
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o) else $error("input stalled with no result pending");

  // Input stall rises only after the output was held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without output back-pressure");

  // Results stay in range
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mag_latitude_o <= 18'sd92160) && (mag_latitude_o >= -18'sd92160)
                    && (mag_longitude_o < 19'd368640))
    else $error("result out of range");

  // A held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mag_latitude_o)
                                   && $stable(mag_longitude_o)
                                   && $stable(low_latitude_flag_o))
    else $error("held result changed");

endmodule

bind geomagnetic_coordinate_rotation_top gmrot_checker u_gmrot_checker (.*);
`default_nettype wire
